// ===== rtl/core/imhq_pkg.sv =====
`timescale 1ns / 1ps
package imhq_pkg;
  localparam int unsigned KeyW  = 32;
  localparam int unsigned PayW  = 32;
  localparam int unsigned IdW   = 8;
  localparam int unsigned PosW  = 8;
  localparam int unsigned Depth = 256;

  localparam logic [1:0] ReqInsert  = 2'd0;
  localparam logic [1:0] ReqChange  = 2'd1;
  localparam logic [1:0] ReqExtract = 2'd2;
  localparam logic [1:0] ReqRemove  = 2'd3;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StFull    = 3'd1;
  localparam logic [2:0] StPresent = 3'd2;
  localparam logic [2:0] StAbsent  = 3'd3;
  localparam logic [2:0] StEmpty   = 3'd4;

  // datapath command opcodes
  typedef enum logic [3:0] {
    CmdNone,
    CmdLoadReq,   // capture request, read position table
    CmdReadSlot,  // read slot at cur position
    CmdLatchSlot, // latch slot read data as work entry (or old entry)
    CmdInsert,    // count++, cur = count, work = request
    CmdTakeOut,   // clear id position, count--, read last slot
    CmdFill,      // work = last slot, compare with old key
    CmdNewKey,    // work key = request key
    CmdReadPar,   // read parent slot
    CmdReadKids,  // read child c (first)
    CmdReadKid2,  // read child c+1
    CmdPickKid,   // keep the smaller child
    CmdMoveUp,    // place parent at cur, cur = parent
    CmdMoveDown,  // place child at cur, cur = child
    CmdPlace      // place work at cur
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
  } ctl_t;

  typedef struct packed {
    logic [1:0] req;
    logic       count_full;
    logic       count_zero;
    logic       pos_zero;    // looked-up position absent
    logic       at_root;
    logic       up_less;     // work key < parent key
    logic       has_child;
    logic       has_kid2;
    logic       down_less;   // chosen child < work key
    logic       fill_gt;     // filled key greater than old
    logic       fill_lt;
    logic       last_taken;  // taken slot was the last slot
  } sts_t;
endpackage

// ===== rtl/core/imhq_datapath.sv =====
`timescale 1ns / 1ps
module imhq_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  imhq_pkg::ctl_t             ctl_i,
  input  logic [1:0]                 req_type_i,
  input  logic [imhq_pkg::IdW-1:0]   item_id_i,
  input  logic signed [imhq_pkg::KeyW-1:0] item_key_i,
  input  logic [imhq_pkg::PayW-1:0]  item_payload_i,
  input  logic [7:0]                 limit_i,
  input  logic                       clr_valid_i,
  output imhq_pkg::sts_t             sts_o,
  output logic [imhq_pkg::IdW-1:0]   res_id_o,
  output logic signed [imhq_pkg::KeyW-1:0] res_key_o,
  output logic [imhq_pkg::PayW-1:0]  res_payload_o
);
  import imhq_pkg::*;

  localparam int unsigned EntW = KeyW + IdW + PayW;

  logic [EntW-1:0] slot_mem [Depth];
  logic [PosW-1:0] pos_mem  [Depth];
  logic [Depth-1:0] pos_vld_q;

  logic [EntW-1:0] rd_q;
  logic [PosW-1:0] pos_rd_q;
  logic [IdW-1:0]  rd_id_q;
  logic [1:0]      req_q;
  logic [IdW-1:0]  id_q;
  logic signed [KeyW-1:0] key_q;
  logic [PayW-1:0] pay_q;
  logic [PosW-1:0] cnt_q, cur_q, kid_q;
  logic [EntW-1:0] work_q, kid_ent_q;
  logic signed [KeyW-1:0] old_key_q;
  logic [PayW-1:0] old_pay_q;
  logic [IdW-1:0]  old_id_q;
  logic            last_q;

  logic [PosW:0]   kid1, kid2;
  logic            wr_en;
  logic [PosW-1:0] wr_addr;
  logic [EntW-1:0] wr_data;
  logic            rd_en;
  logic [PosW-1:0] rd_addr;

  function automatic logic signed [KeyW-1:0] key_of(logic [EntW-1:0] e);
    return e[EntW-1 -: KeyW];
  endfunction
  function automatic logic [IdW-1:0] id_of(logic [EntW-1:0] e);
    return e[PayW +: IdW];
  endfunction

  assign kid1 = {cur_q, 1'b0};
  assign kid2 = {cur_q, 1'b1};

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur_q;
    wr_data = work_q;
    rd_en   = 1'b0;
    rd_addr = cur_q;
    unique case (ctl_i.cmd)
      CmdReadSlot: rd_en = 1'b1;
      CmdTakeOut: begin
        rd_en = 1'b1;
        rd_addr = cnt_q;
      end
      CmdReadPar: begin
        rd_en = 1'b1;
        rd_addr = {1'b0, cur_q[PosW-1:1]};
      end
      CmdReadKids: begin
        rd_en = 1'b1;
        rd_addr = kid1[PosW-1:0];
      end
      CmdReadKid2: begin
        rd_en = 1'b1;
        rd_addr = kid2[PosW-1:0];
      end
      CmdMoveUp: begin
        wr_en = 1'b1;
        wr_data = rd_q;
      end
      CmdMoveDown: begin
        wr_en = 1'b1;
        wr_data = kid_ent_q;
      end
      CmdPlace: wr_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) slot_mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= slot_mem[rd_addr];
  end

  // position table: one write port, one read port, valid bits for reset
  logic            pw_en;
  logic [IdW-1:0]  pw_addr;
  logic [PosW-1:0] pw_data;
  logic [IdW-1:0]  pr_addr;
  logic            pr_en;

  always_comb begin
    pw_en   = wr_en;
    pw_addr = id_of(wr_data);
    pw_data = wr_addr;
    pr_en   = ctl_i.cmd == CmdLoadReq;
    pr_addr = item_id_i;
    if (ctl_i.cmd == CmdTakeOut) begin
      pw_en   = 1'b1;
      pw_addr = old_id_q;
      pw_data = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pw_en) pos_mem[pw_addr] <= pw_data;
    if (pr_en) begin
      pos_rd_q <= pos_mem[pr_addr];
      rd_id_q  <= pr_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_vld_q <= '0;
      cnt_q     <= '0;
    end else begin
      if (clr_valid_i) pos_vld_q <= '0;
      if (pw_en) pos_vld_q[pw_addr] <= 1'b1;
      if (ctl_i.cmd == CmdInsert) cnt_q <= cnt_q + 1'b1;
      if (ctl_i.cmd == CmdTakeOut) cnt_q <= cnt_q - 1'b1;
    end
  end

  logic [PosW-1:0] pos_look;
  assign pos_look = pos_vld_q[rd_id_q] ? pos_rd_q : '0;

  // child select: kid1 is registered first, kid2 replaces it only when smaller
  logic kid2_pick;
  assign kid2_pick = key_of(rd_q) < key_of(kid_ent_q);

  always_ff @(posedge clk_i) begin
    unique case (ctl_i.cmd)
      CmdLoadReq: begin
        req_q <= req_type_i;
        id_q  <= item_id_i;
        key_q <= item_key_i;
        pay_q <= item_payload_i;
        cur_q <= 8'd1;
      end
      // hold the looked-up position in cur for change and remove
      CmdReadSlot: if (req_q != ReqExtract) cur_q <= pos_look;
      CmdLatchSlot: begin
        work_q    <= rd_q;
        old_key_q <= key_of(rd_q);
        old_pay_q <= rd_q[PayW-1:0];
        old_id_q  <= id_of(rd_q);
      end
      CmdInsert: begin
        cur_q  <= cnt_q + 1'b1;
        work_q <= {key_q, id_q, pay_q};
      end
      CmdTakeOut: last_q <= (cur_q == cnt_q);
      CmdFill: work_q <= rd_q;
      CmdNewKey: work_q[EntW-1 -: KeyW] <= key_q;
      CmdReadKids: kid_q <= kid1[PosW-1:0];
      CmdReadKid2: begin
        kid_q     <= kid1[PosW-1:0];
        kid_ent_q <= rd_q;
      end
      CmdPickKid: if (sts_o.has_kid2 && kid2_pick) begin
        kid_q     <= kid2[PosW-1:0];
        kid_ent_q <= rd_q;
      end
      CmdMoveUp: cur_q <= {1'b0, cur_q[PosW-1:1]};
      CmdMoveDown: cur_q <= kid_q;
      default: ;
    endcase
  end

  assign sts_o.req        = req_q;
  assign sts_o.count_full = cnt_q >= limit_i;
  assign sts_o.count_zero = cnt_q == '0;
  assign sts_o.pos_zero   = (pos_look == '0) || (pos_look > cnt_q);
  assign sts_o.at_root    = cur_q == 8'd1;
  assign sts_o.up_less    = key_of(work_q) < key_of(rd_q);
  assign sts_o.has_child  = kid1 <= {1'b0, cnt_q};
  assign sts_o.has_kid2   = kid2 <= {1'b0, cnt_q};
  assign sts_o.down_less  = key_of(kid_ent_q) < key_of(work_q);
  assign sts_o.fill_gt    = old_key_q < key_of(work_q);
  assign sts_o.fill_lt    = key_of(work_q) < old_key_q;
  assign sts_o.last_taken = last_q;

  assign res_id_o      = old_id_q;
  assign res_key_o     = old_key_q;
  assign res_payload_o = old_pay_q;
endmodule

// ===== rtl/core/imhq_ctrl.sv =====
`timescale 1ns / 1ps
module imhq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_go_i,
  input  imhq_pkg::sts_t sts_i,
  input  logic           out_free_i,
  output imhq_pkg::ctl_t ctl_o,
  output logic           busy_o,
  output logic           done_o,
  output logic [2:0]     status_o,
  output logic           take_o
);
  import imhq_pkg::*;

  localparam logic [4:0] SIdle   = 5'd0;
  localparam logic [4:0] SLook   = 5'd1;
  localparam logic [4:0] SDecide = 5'd2;
  localparam logic [4:0] SRd     = 5'd3;
  localparam logic [4:0] SLatch  = 5'd4;
  localparam logic [4:0] STake   = 5'd5;
  localparam logic [4:0] SFillW  = 5'd6;
  localparam logic [4:0] SFill   = 5'd7;
  localparam logic [4:0] SFork   = 5'd8;
  localparam logic [4:0] SUpRd   = 5'd9;
  localparam logic [4:0] SUpWait = 5'd10;
  localparam logic [4:0] SUpCmp  = 5'd11;
  localparam logic [4:0] SDnRd   = 5'd12;
  localparam logic [4:0] SDnRd2  = 5'd13;
  localparam logic [4:0] SDnW1   = 5'd14;
  localparam logic [4:0] SDnSel  = 5'd15;
  localparam logic [4:0] SDnCmp  = 5'd16;
  localparam logic [4:0] SPlace  = 5'd17;
  localparam logic [4:0] SDone   = 5'd18;
  localparam logic [4:0] SNewKey = 5'd19;

  logic [4:0] state_q, state_d;
  logic [2:0] st_q, st_d;
  logic       take_q, take_d;
  logic       dir_up_q, dir_up_d;

  always_comb begin
    state_d   = state_q;
    st_d      = st_q;
    take_d    = take_q;
    dir_up_d  = dir_up_q;
    ctl_o.cmd = CmdNone;
    unique case (state_q)
      SIdle: if (in_go_i) begin
        ctl_o.cmd = CmdLoadReq;
        st_d      = StOk;
        take_d    = 1'b0;
        state_d   = SLook;
      end
      SLook: state_d = SDecide;
      SDecide: begin
        priority if (sts_i.req == ReqInsert) begin
          if (sts_i.count_full) begin
            st_d = StFull; state_d = SDone;
          end else if (!sts_i.pos_zero) begin
            st_d = StPresent; state_d = SDone;
          end else begin
            ctl_o.cmd = CmdInsert; dir_up_d = 1'b1; state_d = SFork;
          end
        end else if (sts_i.req == ReqExtract) begin
          if (sts_i.count_zero) begin
            st_d = StEmpty; state_d = SDone;
          end else begin
            ctl_o.cmd = CmdReadSlot; state_d = SRd;
          end
        end else begin
          if (sts_i.pos_zero) begin
            st_d = StAbsent; state_d = SDone;
          end else begin
            ctl_o.cmd = CmdReadSlot; state_d = SRd;
          end
        end
      end
      SRd: begin
        ctl_o.cmd = CmdReadSlot; state_d = SLatch;
      end
      SLatch: begin
        ctl_o.cmd = CmdLatchSlot;
        state_d = (sts_i.req == ReqChange) ? SNewKey : STake;
      end
      SNewKey: begin
        ctl_o.cmd = CmdNewKey; state_d = SFill;
      end
      STake: begin
        ctl_o.cmd = CmdTakeOut; take_d = 1'b1; state_d = SFillW;
      end
      SFillW: begin
        if (sts_i.last_taken) state_d = SDone;
        else begin
          ctl_o.cmd = CmdFill; state_d = SFill;
        end
      end
      SFill: begin
        if (sts_i.fill_gt) begin
          dir_up_d = 1'b0; state_d = SFork;
        end else if (sts_i.fill_lt) begin
          dir_up_d = 1'b1; state_d = SFork;
        end else state_d = SPlace;
      end
      SFork: state_d = dir_up_q ? SUpRd : SDnRd;
      SUpRd: if (sts_i.at_root) state_d = SPlace;
      else begin
        ctl_o.cmd = CmdReadPar; state_d = SUpWait;
      end
      SUpWait: state_d = SUpCmp;
      SUpCmp: if (sts_i.up_less) begin
        ctl_o.cmd = CmdMoveUp; state_d = SUpRd;
      end else state_d = SPlace;
      SDnRd: if (!sts_i.has_child) state_d = SPlace;
      else begin
        ctl_o.cmd = CmdReadKids; state_d = SDnW1;
      end
      SDnW1: begin
        ctl_o.cmd = CmdReadKid2; state_d = SDnRd2;
      end
      SDnRd2: begin
        ctl_o.cmd = CmdPickKid; state_d = SDnSel;
      end
      SDnSel: state_d = SDnCmp;
      SDnCmp: if (sts_i.down_less) begin
        ctl_o.cmd = CmdMoveDown; state_d = SDnRd;
      end else state_d = SPlace;
      SPlace: begin
        ctl_o.cmd = CmdPlace; state_d = SDone;
      end
      SDone: if (out_free_i) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      st_q     <= StOk;
      take_q   <= 1'b0;
      dir_up_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      st_q     <= st_d;
      take_q   <= take_d;
      dir_up_q <= dir_up_d;
    end
  end

  assign busy_o   = state_q != SIdle;
  assign done_o   = state_q == SDone;
  assign status_o = st_q;
  assign take_o   = take_q;
endmodule

// ===== rtl/core/indexed_min_heap_queue.sv =====
`timescale 1ns / 1ps
// Indexed binary min-heap queue, one request at a time.
// Sifts over up to 7 moves, one slot memory read or write per step; the
// block takes no new request until the last one is done. The result beat
// sits in an output register, so the next request is taken while it waits.
// Reset: asynchronous active low; clears count, id valid bits, limit to 255.
module indexed_min_heap_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  item_id_i,
  input  logic signed [31:0] item_key_i,
  input  logic [31:0] item_payload_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [7:0]  out_id_o,
  output logic signed [31:0] out_key_o,
  output logic [31:0] out_payload_o,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i
);
  import imhq_pkg::*;

  ctl_t ctl;
  sts_t sts;
  logic busy, done, take;
  logic [2:0] st;
  logic [7:0] limit_q;
  logic [IdW-1:0] r_id;
  logic signed [KeyW-1:0] r_key;
  logic [PayW-1:0] r_pay;
  logic out_free, go;

  // configuration register: the user must write it only between requests; the block itself does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) limit_q <= 8'd255;
    else if (cfg_we_i) limit_q <= cfg_wdata_i;
  end

  // output register frees when empty or being taken this edge
  assign out_free   = !out_valid_o || !out_stall_i;
  assign in_stall_o = busy;
  assign go         = in_valid_i && !busy;

  imhq_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_go_i(go), .sts_i(sts), .out_free_i(out_free),
    .ctl_o(ctl), .busy_o(busy), .done_o(done), .status_o(st), .take_o(take)
  );

  imhq_datapath u_dp (
    .clk_i, .rst_ni, .ctl_i(ctl), .req_type_i, .item_id_i, .item_key_i,
    .item_payload_i, .limit_i(limit_q), .clr_valid_i(1'b0), .sts_o(sts),
    .res_id_o(r_id), .res_key_o(r_key), .res_payload_o(r_pay)
  );

  // result beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (done && out_free) out_valid_o <= 1'b1;
    else if (!out_stall_i) out_valid_o <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (done && out_free) begin
      status_o      <= st;
      out_id_o      <= (take && sts.req == ReqExtract) ? r_id : '0;
      out_key_o     <= take ? r_key : '0;
      out_payload_o <= take ? r_pay : '0;
    end
  end

  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> in_stall_o) else $error("accept while busy");
  a_done_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done && out_free) |=> out_valid_o) else $error("result beat lost");
  a_zero_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != StOk) |-> (out_id_o == '0))
    else $error("id on failed request");
endmodule
